### rtl/usbdfu_pkg.sv
// ----------------------------------------------------------------------------
// USB DFU request state machine package
// Word types, DFU state, status, action and request codes shared by the
// decision logic and the top level.
// ----------------------------------------------------------------------------
package usbdfu_pkg;

  // Event codes of an input word.
  localparam logic [2:0] OP_CONTROL    = 3'd0;
  localparam logic [2:0] OP_DN_DATA    = 3'd1;
  localparam logic [2:0] OP_WRITE_DONE = 3'd2;
  localparam logic [2:0] OP_READ_DONE  = 3'd3;
  localparam logic [2:0] OP_UP_SENT    = 3'd4;
  localparam logic [2:0] OP_SERVICE    = 3'd5;

  // DFU class request codes (bRequest).
  localparam logic [7:0] REQ_DETACH    = 8'd0;
  localparam logic [7:0] REQ_DNLOAD    = 8'd1;
  localparam logic [7:0] REQ_UPLOAD    = 8'd2;
  localparam logic [7:0] REQ_GETSTATUS = 8'd3;
  localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
  localparam logic [7:0] REQ_GETSTATE  = 8'd5;
  localparam logic [7:0] REQ_ABORT     = 8'd6;

  // DFU 1.1 state numbers.
  localparam logic [3:0] ST_IDLE     = 4'd2;
  localparam logic [3:0] ST_DN_SYNC  = 4'd3;
  localparam logic [3:0] ST_DN_BUSY  = 4'd4;
  localparam logic [3:0] ST_DN_IDLE  = 4'd5;
  localparam logic [3:0] ST_MAN_SYNC = 4'd6;
  localparam logic [3:0] ST_MAN      = 4'd7;
  localparam logic [3:0] ST_MAN_WAIT = 4'd8;
  localparam logic [3:0] ST_UP_IDLE  = 4'd9;
  localparam logic [3:0] ST_ERROR    = 4'd10;

  // DFU 1.1 status codes.
  localparam logic [3:0] SS_OK       = 4'd0;
  localparam logic [3:0] SS_WRITE    = 4'd3;
  localparam logic [3:0] SS_ADDRESS  = 4'd8;
  localparam logic [3:0] SS_FIRMWARE = 4'd10;
  localparam logic [3:0] SS_UNKNOWN  = 4'd14;

  // Action codes of a result word.
  localparam logic [3:0] ACT_ACK     = 4'd0;
  localparam logic [3:0] ACT_STALL   = 4'd1;
  localparam logic [3:0] ACT_STATUS  = 4'd2;
  localparam logic [3:0] ACT_STATE   = 4'd3;
  localparam logic [3:0] ACT_RECEIVE = 4'd4;
  localparam logic [3:0] ACT_READ    = 4'd5;
  localparam logic [3:0] ACT_WRITE   = 4'd6;
  localparam logic [3:0] ACT_UPLOAD  = 4'd7;
  localparam logic [3:0] ACT_ZLP     = 4'd8;
  localparam logic [3:0] ACT_NONE    = 4'd9;

  // Poll timeouts reported with a status reply.
  localparam logic [6:0] POLL_SHORT = 7'd1;
  localparam logic [6:0] POLL_LONG  = 7'd100;

  // Fixed reply lengths.
  localparam logic [15:0] LEN_STATUS = 16'd6;
  localparam logic [15:0] LEN_STATE  = 16'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PAGE_SIZE_LOG2 = 2'd0;
  localparam logic [1:0] CFG_FIRST_PAGE     = 2'd1;
  localparam logic [1:0] CFG_PAGE_LIMIT     = 2'd2;

  localparam logic [3:0] PAGE_SIZE_LOG2_RST = 4'd7;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  request_code;
    logic        to_host;
    logic [15:0] setup_value;
    logic [15:0] setup_length;
    logic        mem_failed;
  } usbdfu_in_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  dfu_state_out;
    logic [3:0]  dfu_status_out;
    logic [6:0]  poll_timeout;
    logic [31:0] page_number;
    logic [15:0] transfer_length;
    logic        reboot;
  } usbdfu_out_t;

  // Protocol context kept between events.
  typedef struct packed {
    logic [3:0]  dfu_state;
    logic [3:0]  dfu_status;
    logic [31:0] block_counter;
    logic        memory_busy;
  } usbdfu_ctx_t;

  // Configuration register contents.
  typedef struct packed {
    logic [3:0]  page_size_log2;
    logic [31:0] first_page;
    logic [31:0] page_limit;
  } usbdfu_cfg_t;

endpackage

### rtl/usb_dfu_request_state_machine.sv
// ----------------------------------------------------------------------------
// USB DFU request state machine
// Device side of the DFU 1.1 request protocol: one result word per event.
// ----------------------------------------------------------------------------
// The block takes one event word per clock while in_stall_o is low and
// returns exactly one result word for it from a register. The decision
// is made in a single pass from the stored DFU context and the incoming
// word, and the context is updated at the same edge, so a new event may
// follow in the very next cycle. A result register with a one-word skid
// stage sits on the output: in_stall_o rises only when both are full, and
// it is driven from a register. Configuration registers are written
// through the plain write port and take effect on the next event.
module usb_dfu_request_state_machine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  // Event words.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  usbdfu_pkg::usbdfu_in_t   in_data_i,
  // Result words.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output usbdfu_pkg::usbdfu_out_t  out_data_o
);
  import usbdfu_pkg::*;

  usbdfu_cfg_t cfg_q;
  usbdfu_ctx_t ctx_q;
  usbdfu_ctx_t ctx_d;
  usbdfu_out_t result;
  usbdfu_out_t out_q;
  usbdfu_out_t skid_q;
  logic        out_valid_q;
  logic        skid_valid_q;
  logic        in_accept;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_size_log2 <= PAGE_SIZE_LOG2_RST;
      cfg_q.first_page     <= '0;
      cfg_q.page_limit     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAGE_SIZE_LOG2: cfg_q.page_size_log2 <= cfg_data_i[3:0];
        CFG_FIRST_PAGE:     cfg_q.first_page     <= cfg_data_i;
        CFG_PAGE_LIMIT:     cfg_q.page_limit     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Event decision.
  usbdfu_decide u_decide (
    .ctx_i  (ctx_q),
    .cfg_i  (cfg_q),
    .word_i (in_data_i),
    .ctx_o  (ctx_d),
    .word_o (result)
  );

  // Protocol context, updated on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.dfu_state     <= ST_IDLE;
      ctx_q.dfu_status    <= SS_OK;
      ctx_q.block_counter <= '0;
      ctx_q.memory_busy   <= 1'b0;
    end else if (in_accept) begin
      ctx_q <= ctx_d;
    end
  end

  // Output register with a one-word skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= result;
      end
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

endmodule

### rtl/usbdfu_decide.sv
// ----------------------------------------------------------------------------
// USB DFU event decision logic
// Works out, for one event word, the next protocol context and the result
// word, from the present context and the configuration.
// ----------------------------------------------------------------------------
module usbdfu_decide (
  input  usbdfu_pkg::usbdfu_ctx_t ctx_i,
  input  usbdfu_pkg::usbdfu_cfg_t cfg_i,
  input  usbdfu_pkg::usbdfu_in_t  word_i,
  output usbdfu_pkg::usbdfu_ctx_t ctx_o,
  output usbdfu_pkg::usbdfu_out_t word_o
);
  import usbdfu_pkg::*;

  logic [15:0] page_bytes;
  logic [31:0] next_block;
  logic        block_wrap;
  logic        setup_zero;

  // Page size in bytes; the largest page, 32 KiB, still fits 16 bits.
  assign page_bytes = 16'd1 << cfg_i.page_size_log2;

  // Block counter from wValue, carried into the upper half when the low
  // half wraps from all ones to zero.
  assign block_wrap = (ctx_i.block_counter[15:0] == 16'hffff) && (word_i.setup_value == 16'd0);
  assign next_block = block_wrap ? {ctx_i.block_counter[31:16] + 16'd1, 16'd0}
                                 : {ctx_i.block_counter[31:16], word_i.setup_value};

  assign setup_zero = (word_i.setup_value == 16'd0);

  always_comb begin
    ctx_o  = ctx_i;
    word_o = '0;
    word_o.action = ACT_NONE;

    unique case (word_i.operation)
      OP_CONTROL: begin
        word_o.action = ACT_STALL;
        if (word_i.request_code == REQ_UPLOAD && word_i.to_host) begin
          // Upload request: only from the idle and upload-idle states with the memory free.
          if ((ctx_i.dfu_state == ST_UP_IDLE || ctx_i.dfu_state == ST_IDLE) &&
              !ctx_i.memory_busy) begin
            ctx_o.dfu_state = ST_UP_IDLE;
            if (word_i.setup_length != page_bytes) begin
              ctx_o.dfu_status = SS_FIRMWARE;
              ctx_o.dfu_state  = ST_ERROR;
            end else begin
              ctx_o.block_counter = next_block;
              if (next_block >= cfg_i.page_limit) begin
                ctx_o.dfu_status = SS_ADDRESS;
                ctx_o.dfu_state  = ST_ERROR;
              end else begin
                ctx_o.memory_busy      = 1'b1;
                word_o.action          = ACT_READ;
                word_o.page_number     = next_block + cfg_i.first_page;
                word_o.transfer_length = page_bytes;
              end
            end
          end
        end else if (word_i.request_code == REQ_GETSTATUS) begin
          // Status poll also moves the synchronisation and manifestation states on.
          if (setup_zero && word_i.to_host && word_i.setup_length == LEN_STATUS) begin
            word_o.poll_timeout = POLL_LONG;
            if (ctx_i.dfu_state == ST_DN_SYNC) begin
              ctx_o.dfu_state     = ST_DN_IDLE;
              word_o.poll_timeout = POLL_SHORT;
            end else if (ctx_i.dfu_state == ST_MAN_SYNC) begin
              ctx_o.dfu_state     = ST_MAN;
              word_o.poll_timeout = POLL_SHORT;
            end else if (ctx_i.dfu_state == ST_MAN) begin
              ctx_o.dfu_state     = ST_MAN_WAIT;
              word_o.poll_timeout = POLL_SHORT;
              word_o.reboot       = 1'b1;
            end
            word_o.action          = ACT_STATUS;
            word_o.transfer_length = LEN_STATUS;
          end
        end else if (word_i.request_code == REQ_CLRSTATUS ||
                     word_i.request_code == REQ_ABORT) begin
          // Clear or abort returns to idle; the busy flag is left alone.
          if (setup_zero && !word_i.to_host && word_i.setup_length == 16'd0) begin
            ctx_o.dfu_status    = SS_OK;
            ctx_o.dfu_state     = ST_IDLE;
            ctx_o.block_counter = '0;
            word_o.action       = ACT_ACK;
          end
        end else if (word_i.request_code == REQ_GETSTATE) begin
          if (setup_zero && word_i.to_host && word_i.setup_length == LEN_STATE) begin
            word_o.action          = ACT_STATE;
            word_o.transfer_length = LEN_STATE;
          end
        end else if (word_i.request_code == REQ_DNLOAD && !word_i.to_host) begin
          // Download request: a zero length starts manifestation.
          if ((ctx_i.dfu_state == ST_DN_IDLE || ctx_i.dfu_state == ST_IDLE) &&
              !ctx_i.memory_busy) begin
            ctx_o.dfu_state = ST_ERROR;
            if (word_i.setup_length == 16'd0) begin
              ctx_o.dfu_state = ST_MAN_SYNC;
              word_o.action   = ACT_ACK;
            end else if (word_i.setup_length > page_bytes) begin
              ctx_o.dfu_status = SS_FIRMWARE;
            end else begin
              ctx_o.block_counter    = next_block;
              word_o.action          = ACT_RECEIVE;
              word_o.page_number     = next_block + cfg_i.first_page;
              word_o.transfer_length = word_i.setup_length;
            end
          end
        end
      end

      OP_DN_DATA: begin
        ctx_o.dfu_state        = ST_DN_BUSY;
        ctx_o.memory_busy      = 1'b1;
        word_o.action          = ACT_WRITE;
        word_o.page_number     = ctx_i.block_counter + cfg_i.first_page;
        word_o.transfer_length = page_bytes;
      end

      OP_WRITE_DONE: begin
        ctx_o.memory_busy = 1'b0;
        if (ctx_i.dfu_state == ST_DN_BUSY) begin
          if (word_i.mem_failed) begin
            ctx_o.dfu_status = SS_WRITE;
            ctx_o.dfu_state  = ST_ERROR;
          end else begin
            ctx_o.dfu_state = ST_DN_SYNC;
          end
        end
      end

      OP_READ_DONE: begin
        ctx_o.memory_busy = 1'b0;
        if (word_i.mem_failed) begin
          ctx_o.dfu_status = SS_UNKNOWN;
          ctx_o.dfu_state  = ST_ERROR;
          word_o.action    = ACT_ZLP;
        end else begin
          word_o.action          = ACT_UPLOAD;
          word_o.transfer_length = page_bytes;
        end
      end

      default: begin
        // Upload sent, service events and unused codes change nothing.
        word_o.action = ACT_NONE;
      end
    endcase

    word_o.dfu_state_out  = ctx_o.dfu_state;
    word_o.dfu_status_out = ctx_o.dfu_status;
  end

endmodule
